FILE: src/translation_block_lookup_cache_assert.svh
// Assertion macros used by the lookup cache datapath.
`ifndef TRANSLATION_BLOCK_LOOKUP_CACHE_ASSERT_SVH
`define TRANSLATION_BLOCK_LOOKUP_CACHE_ASSERT_SVH

`ifndef ASSERT_OFF
`define TBLC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define TBLC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TBLC_ASSERT(lbl, clk, rstn, prop, msg)
`define TBLC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: src/tblc_pkg.sv
package tblc_pkg;

  localparam int CACHE_BITS  = 8;
  localparam int CACHE_SIZE  = 1 << CACHE_BITS;
  localparam int SLOT_W      = CACHE_BITS;
  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int MCNT_W      = 9;
  localparam int MSLOT_W     = 8;
  localparam int ADDR_W      = 5;

  localparam logic [1:0] REG_TABLE_COUNT  = 2'd0;
  localparam logic [1:0] REG_CODE_BASE    = 2'd1;
  localparam logic [1:0] REG_MIRROR_COUNT = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RESP_HIT  = 2'd0,
    RESP_FILL = 2'd1,
    RESP_MISS = 2'd2,
    RESP_DONE = 2'd3
  } resp_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CACHE_CHK,
    S_SEARCH,
    S_PROBE,
    S_FINAL,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0]  table_count;
    logic [63:0]       code_base;
    logic [MCNT_W-1:0] mirror_count;
  } cfg_t;

  typedef struct packed {
    logic  capture;
    logic  load_we;
    logic  flush;
    logic  search_init;
    logic  probe_rd;
    logic  probe_upd;
    logic  final_rd;
    logic  fill;
    logic  res_we;
    resp_e res_kind;
    logic  out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic base_zero;
    logic lo_lt_hi;
    logic match;
    logic out_free;
  } dp_status_t;

endpackage

FILE: src/tblc_in_if.sv
interface tblc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] lookup_pc;
  logic [11:0] entry_index;
  logic [63:0] entry_pc;
  logic [31:0] entry_flags;
  logic [31:0] entry_offset;

  modport source (
    output valid, cmd, lookup_pc, entry_index, entry_pc, entry_flags, entry_offset,
    input  ready
  );
  modport sink (
    input  valid, cmd, lookup_pc, entry_index, entry_pc, entry_flags, entry_offset,
    output ready
  );
endinterface

FILE: src/tblc_out_if.sv
interface tblc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] target;
  logic        mirror_write;
  logic [7:0]  mirror_slot;

  modport source (
    output valid, status, target, mirror_write, mirror_slot,
    input  ready
  );
  modport sink (
    input  valid, status, target, mirror_write, mirror_slot,
    output ready
  );
endinterface

FILE: src/tblc_regs.sv
module tblc_regs
  import tblc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[ADDR_W-1:3];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TABLE_COUNT:  cfg_q.table_count  <= pwdata[CNT_W-1:0];
        REG_CODE_BASE:    cfg_q.code_base    <= pwdata;
        REG_MIRROR_COUNT: cfg_q.mirror_count <= pwdata[MCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TABLE_COUNT:  prdata = 64'(cfg_q.table_count);
      REG_CODE_BASE:    prdata = cfg_q.code_base;
      REG_MIRROR_COUNT: prdata = 64'(cfg_q.mirror_count);
      default:          prdata = '0;
    endcase
  end

endmodule

FILE: src/tblc_ctrl.sv
module tblc_ctrl
  import tblc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  cmd_e       in_cmd_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_cmd_i == CMD_LOOKUP) ? S_CACHE_CHK : S_RESP;
        end
      end
      S_CACHE_CHK: begin
        if (status_i.hit || status_i.base_zero) begin
          state_d = S_RESP;
        end else begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: state_d = status_i.lo_lt_hi ? S_PROBE : S_FINAL;
      S_PROBE:  state_d = S_SEARCH;
      S_FINAL:  state_d = S_RESP;
      S_RESP: begin
        if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.res_kind = RESP_DONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_cmd_i)
            CMD_LOOKUP: cmd_o.capture = 1'b1;
            CMD_LOAD: begin
              cmd_o.load_we = 1'b1;
              cmd_o.res_we  = 1'b1;
            end
            CMD_FLUSH: begin
              cmd_o.flush  = 1'b1;
              cmd_o.res_we = 1'b1;
            end
            default: cmd_o.res_we = 1'b1;
          endcase
        end
      end
      S_CACHE_CHK: begin
        if (status_i.hit) begin
          cmd_o.res_we   = 1'b1;
          cmd_o.res_kind = RESP_HIT;
        end else if (status_i.base_zero) begin
          cmd_o.res_we   = 1'b1;
          cmd_o.res_kind = RESP_MISS;
        end else begin
          cmd_o.search_init = 1'b1;
        end
      end
      S_SEARCH: begin
        if (status_i.lo_lt_hi) begin
          cmd_o.probe_rd = 1'b1;
        end else begin
          cmd_o.final_rd = 1'b1;
        end
      end
      S_PROBE: cmd_o.probe_upd = 1'b1;
      S_FINAL: begin
        cmd_o.res_we = 1'b1;
        if (status_i.match) begin
          cmd_o.fill     = 1'b1;
          cmd_o.res_kind = RESP_FILL;
        end else begin
          cmd_o.res_kind = RESP_MISS;
        end
      end
      S_RESP: cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

endmodule

FILE: src/tblc_dpath.sv
`include "translation_block_lookup_cache_assert.svh"

module tblc_dpath
  import tblc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  ctrl_cmd_t          cmd_i,
  output dp_status_t         status_o,
  input  logic [63:0]        in_lookup_pc_i,
  input  logic [IDX_W-1:0]   in_entry_index_i,
  input  logic [63:0]        in_entry_pc_i,
  input  logic [31:0]        in_entry_flags_i,
  input  logic [31:0]        in_entry_offset_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         out_status_o,
  output logic [63:0]        out_target_o,
  output logic               out_mirror_write_o,
  output logic [MSLOT_W-1:0] out_mirror_slot_o
);

  logic [63:0] ctag_mem [CACHE_SIZE];
  logic [63:0] ctgt_mem [CACHE_SIZE];
  logic [63:0] tpc_mem  [TABLE_DEPTH];
  logic [31:0] tflg_mem [TABLE_DEPTH];
  logic [31:0] toff_mem [TABLE_DEPTH];

  logic [CACHE_SIZE-1:0] cvalid_q;
  logic [SLOT_W-1:0]     in_slot;
  logic [SLOT_W-1:0]     slot_q;
  logic [63:0]           pc_q;
  logic [63:0]           ctag_rd_q;
  logic [63:0]           ctgt_rd_q;
  logic                  cvalid_rd_q;
  logic [63:0]           tpc_rd_q;
  logic [31:0]           tflg_rd_q;
  logic [31:0]           toff_rd_q;
  logic [CNT_W-1:0]      lo_q, hi_q, mid_q;
  logic [CNT_W-1:0]      mid, n_eff;
  logic [IDX_W-1:0]      rd_addr;
  logic                  lo_lt_n;
  logic [63:0]           fill_target;
  logic                  mirror_hit;

  resp_e                 res_status_q;
  logic [63:0]           res_target_q;
  logic                  res_mwrite_q;
  logic [MSLOT_W-1:0]    res_mslot_q;
  logic                  out_valid_q;
  logic [1:0]            out_status_q;
  logic [63:0]           out_target_q;
  logic                  out_mwrite_q;
  logic [MSLOT_W-1:0]    out_mslot_q;

  assign in_slot = SLOT_W'(in_lookup_pc_i ^ (in_lookup_pc_i >> CACHE_BITS));
  assign n_eff   = (cfg_i.table_count > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                             : cfg_i.table_count;
  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign rd_addr = cmd_i.probe_rd ? mid[IDX_W-1:0] : lo_q[IDX_W-1:0];
  assign lo_lt_n = lo_q < n_eff;
  assign fill_target = cfg_i.code_base + 64'(toff_rd_q);
  assign mirror_hit  = MCNT_W'(slot_q) < cfg_i.mirror_count;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ctag_rd_q   <= ctag_mem[in_slot];
      ctgt_rd_q   <= ctgt_mem[in_slot];
      cvalid_rd_q <= cvalid_q[in_slot];
      pc_q        <= in_lookup_pc_i;
      slot_q      <= in_slot;
    end
    if (cmd_i.fill) begin
      ctag_mem[slot_q] <= pc_q;
      ctgt_mem[slot_q] <= fill_target;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && (CNT_W'(in_entry_index_i) < CNT_W'(TABLE_DEPTH))) begin
      tpc_mem[in_entry_index_i]  <= in_entry_pc_i;
      tflg_mem[in_entry_index_i] <= in_entry_flags_i;
      toff_mem[in_entry_index_i] <= in_entry_offset_i;
    end
    if (cmd_i.probe_rd || cmd_i.final_rd) begin
      tpc_rd_q  <= tpc_mem[rd_addr];
      tflg_rd_q <= tflg_mem[rd_addr];
      toff_rd_q <= toff_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvalid_q <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      mid_q    <= '0;
    end else begin
      if (cmd_i.flush) begin
        cvalid_q <= '0;
      end else if (cmd_i.fill) begin
        cvalid_q[slot_q] <= 1'b1;
      end
      if (cmd_i.search_init) begin
        lo_q <= '0;
        hi_q <= n_eff;
      end else if (cmd_i.probe_upd) begin
        if (tpc_rd_q < pc_q) begin
          lo_q <= mid_q + CNT_W'(1);
        end else begin
          hi_q <= mid_q;
        end
      end
      if (cmd_i.probe_rd) begin
        mid_q <= mid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_we) begin
      res_status_q <= cmd_i.res_kind;
      case (cmd_i.res_kind)
        RESP_HIT:  res_target_q <= ctgt_rd_q;
        RESP_FILL: res_target_q <= fill_target;
        default:   res_target_q <= '0;
      endcase
      res_mwrite_q <= (cmd_i.res_kind == RESP_FILL) && mirror_hit;
      res_mslot_q  <= ((cmd_i.res_kind == RESP_FILL) && mirror_hit) ? MSLOT_W'(slot_q)
                                                                     : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_target_q <= res_target_q;
      out_mwrite_q <= res_mwrite_q;
      out_mslot_q  <= res_mslot_q;
    end
  end

  assign status_o.hit       = cvalid_rd_q && (ctag_rd_q == pc_q);
  assign status_o.base_zero = cfg_i.code_base == '0;
  assign status_o.lo_lt_hi  = lo_q < hi_q;
  assign status_o.match     = lo_lt_n && (tpc_rd_q == pc_q) && (tflg_rd_q == '0);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o        = out_valid_q;
  assign out_status_o       = out_status_q;
  assign out_target_o       = out_target_q;
  assign out_mirror_write_o = out_mwrite_q;
  assign out_mirror_slot_o  = out_mslot_q;

  `TBLC_ASSERT(a_lo_le_hi, clk_i, rst_ni, lo_q <= hi_q, "search bounds crossed")
  `TBLC_ASSERT(a_hi_in_table, clk_i, rst_ni, hi_q <= CNT_W'(TABLE_DEPTH), "upper bound past table")
  `TBLC_ASSERT(a_no_overwrite, clk_i, rst_ni, cmd_i.out_load |-> (!out_valid_q || out_ready_i), "pending result overwritten")
  `TBLC_ASSERT(a_fill_match, clk_i, rst_ni, cmd_i.fill |-> (status_o.match && !status_o.base_zero), "cache filled without a table match")
  `TBLC_ASSERT(a_fill_valid, clk_i, rst_ni, cmd_i.fill |=> cvalid_q[$past(slot_q)], "filled slot not valid")

endmodule

FILE: src/translation_block_lookup_cache.sv
// Channel  Dir  Transfer             Payload
// in_i     in   valid & ready        cmd, lookup_pc, entry_index, entry_pc, entry_flags, entry_offset
// out_o    out  valid & ready        status, target, mirror_write, mirror_slot
// apb      in   psel&penable&pwrite  table_count @0x00, code_base @0x08, mirror_count @0x10
//
// Load, flush and unused commands go from the idle state straight to the response state; a cache
// hit, or a miss while code_base is zero, passes the cache check first. Any other miss then runs
// a binary search over up to 4096 entries: each step is one registered read of the table memory.
// One item is in work at a time; the output register holds a result while the next
// item is accepted, and a stalled output holds the block in its response state.
// Reset clears the cache valid bits at once; the table is undefined until loaded.
module translation_block_lookup_cache
  import tblc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  tblc_in_if.sink           in_i,
  tblc_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  cfg_t       cfg;
  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  tblc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tblc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (cmd_e'(in_i.cmd)),
    .in_ready_o (in_i.ready),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  tblc_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .cmd_i              (ctrl_cmd),
    .status_o           (dp_status),
    .in_lookup_pc_i     (in_i.lookup_pc),
    .in_entry_index_i   (in_i.entry_index),
    .in_entry_pc_i      (in_i.entry_pc),
    .in_entry_flags_i   (in_i.entry_flags),
    .in_entry_offset_i  (in_i.entry_offset),
    .out_valid_o        (out_o.valid),
    .out_ready_i        (out_o.ready),
    .out_status_o       (out_o.status),
    .out_target_o       (out_o.target),
    .out_mirror_write_o (out_o.mirror_write),
    .out_mirror_slot_o  (out_o.mirror_slot)
  );

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tblc_pkg::*;

  typedef struct packed {
    resp_e               status;
    logic [63:0]         target;
    logic                mwrite;
    logic [MSLOT_W-1:0]  mslot;
  } tblc_resp_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [63:0]       pwdata;
  logic [63:0]       prdata;
  logic              pready;

  tblc_in_if  in_if ();
  tblc_out_if out_if ();

  translation_block_lookup_cache dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the block's registers, lookup cache and code block table.
  logic [CNT_W-1:0]  count_reg;
  logic [63:0]       base_reg;
  logic [MCNT_W-1:0] mirror_reg;
  logic [63:0]       slot_tag    [CACHE_SIZE];
  logic [63:0]       slot_target [CACHE_SIZE];
  bit                slot_valid  [CACHE_SIZE];
  logic [63:0]       blk_pc      [TABLE_DEPTH];
  logic [31:0]       blk_flags   [TABLE_DEPTH];
  logic [31:0]       blk_offset  [TABLE_DEPTH];

  tblc_resp_t  due_responses [$];
  logic [63:0] recent_pcs [$];

  int mismatches;
  int items_sent;
  int burst_left;
  int cfg_writes;
  int n_hit;
  int n_fill;
  int n_miss;
  int n_done;
  int n_mirror;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Computes the response to one command and applies its effect on the shadow state.
  function automatic tblc_resp_t resolve_command(cmd_e cmd, logic [63:0] pc, logic [11:0] idx,
                                                 logic [63:0] epc, logic [31:0] eflags,
                                                 logic [31:0] eoff);
    tblc_resp_t        r;
    logic [SLOT_W-1:0] slot;
    int                n;
    int                lo;
    int                hi;
    int                mid;
    r.status = RESP_DONE;
    r.target = '0;
    r.mwrite = 1'b0;
    r.mslot  = '0;
    case (cmd)
      CMD_LOOKUP: begin
        slot = SLOT_W'(pc ^ (pc >> CACHE_BITS));
        if (slot_valid[slot] && slot_tag[slot] == pc) begin
          r.status = RESP_HIT;
          r.target = slot_target[slot];
        end else begin
          r.status = RESP_MISS;
          if (base_reg != 64'd0) begin
            n = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_reg);
            lo = 0;
            hi = n;
            while (lo < hi) begin
              mid = lo + (hi - lo) / 2;
              if (blk_pc[mid] < pc) lo = mid + 1;
              else hi = mid;
            end
            if (lo < n && blk_pc[lo] == pc && blk_flags[lo] == 32'd0) begin
              r.status = RESP_FILL;
              r.target = base_reg + 64'(blk_offset[lo]);
              slot_tag[slot]    = pc;
              slot_target[slot] = r.target;
              slot_valid[slot]  = 1'b1;
              if (slot < mirror_reg) begin
                r.mwrite = 1'b1;
                r.mslot  = MSLOT_W'(slot);
              end
            end
          end
        end
      end
      CMD_LOAD: begin
        blk_pc[idx]     = epc;
        blk_flags[idx]  = eflags;
        blk_offset[idx] = eoff;
      end
      CMD_FLUSH: begin
        foreach (slot_valid[i]) begin
          slot_valid[i]  = 1'b0;
          slot_tag[i]    = '1;
          slot_target[i] = '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= 40) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic send_item(cmd_e cmd, logic [63:0] pc, logic [11:0] idx, logic [63:0] epc,
                           logic [31:0] eflags, logic [31:0] eoff);
    int gap;
    in_if.valid        <= 1'b1;
    in_if.cmd          <= cmd;
    in_if.lookup_pc    <= pc;
    in_if.entry_index  <= idx;
    in_if.entry_pc     <= epc;
    in_if.entry_flags  <= eflags;
    in_if.entry_offset <= eoff;
    do @(negedge clk); while (in_if.ready !== 1'b1);
    @(posedge clk);
    due_responses.push_back(resolve_command(cmd, pc, idx, epc, eflags, eoff));
    items_sent++;
    if (cmd == CMD_LOOKUP) begin
      recent_pcs.push_back(pc);
      if (recent_pcs.size() > 8) void'(recent_pcs.pop_front());
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(10, 25);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic lookup(logic [63:0] pc);
    send_item(CMD_LOOKUP, pc, 12'($urandom), rand64(), $urandom, $urandom);
  endtask

  task automatic quiesce();
    in_if.valid <= 1'b0;
    while (due_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (pready !== 1'b1);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TABLE_COUNT:  count_reg  = value[CNT_W-1:0];
      REG_CODE_BASE:    base_reg   = value;
      REG_MIRROR_COUNT: mirror_reg = value[MCNT_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic configure(logic [63:0] count, logic [63:0] base, logic [63:0] mirror);
    quiesce();
    write_reg(REG_TABLE_COUNT, count);
    write_reg(REG_CODE_BASE, base);
    write_reg(REG_MIRROR_COUNT, mirror);
  endtask

  // Fills entries 0..n-1 with keys in ascending (pc, flags) order.
  task automatic load_sorted_table(int n);
    logic [63:0] pc;
    logic [63:0] stride;
    int          i;
    int          r;
    pc = {$urandom_range(0, 32'hFFFF_E000), $urandom};
    i = 0;
    while (i < n) begin
      r = $urandom_range(0, 99);
      if (i < n - 1 && r < 10) begin
        send_item(CMD_LOAD, rand64(), 12'(i), pc, 32'd0, $urandom);
        send_item(CMD_LOAD, rand64(), 12'(i + 1), pc, $urandom | 32'd1, $urandom);
        i += 2;
      end else begin
        send_item(CMD_LOAD, rand64(), 12'(i), pc, (r < 18) ? ($urandom | 32'd1) : 32'd0,
                  $urandom);
        i++;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: stride = 64'($urandom_range(1, 255));
        3, 4:    stride = 64'h101;
        5:       stride = 64'h1_0000;
        default: stride = {32'd0, $urandom} + 64'd1;
      endcase
      pc += stride;
    end
  endtask

  task automatic send_traffic_item(int n);
    int          r;
    int          idx;
    logic [63:0] pc;
    r   = $urandom_range(0, 99);
    idx = $urandom_range(0, n - 1);
    if (r < 50) begin
      lookup(blk_pc[idx]);
    end else if (r < 65 && recent_pcs.size() != 0) begin
      lookup(recent_pcs[$urandom_range(0, recent_pcs.size() - 1)]);
    end else if (r < 73) begin
      pc = blk_pc[idx];
      if ($urandom_range(0, 1) == 1) pc += 64'd1;
      else pc -= 64'd1;
      lookup(pc);
    end else if (r < 80) begin
      lookup(rand64());
    end else if (r < 85) begin
      send_item(CMD_FLUSH, rand64(), 12'($urandom), rand64(), $urandom, $urandom);
    end else if (r < 89) begin
      send_item(CMD_NOP, rand64(), 12'($urandom), rand64(), $urandom, $urandom);
    end else begin
      send_item(CMD_LOAD, rand64(), 12'($urandom), rand64(), $urandom, $urandom);
    end
  endtask

  task automatic test_directed();
    lookup(64'd0);
    lookup('1);
    send_item(CMD_NOP, '1, '1, '1, '1, '1);
    send_item(CMD_FLUSH, '0, '0, '0, '0, '0);
    send_item(CMD_LOAD, '0, 12'd0, 64'd0, 32'd0, 32'd0);
    send_item(CMD_LOAD, '0, 12'd1, 64'd5, 32'd0, 32'hFFFF_FFFF);
    send_item(CMD_LOAD, '0, 12'd2, 64'd5, 32'd7, 32'h0000_1234);
    send_item(CMD_LOAD, '0, 12'd3, 64'd9, 32'd1, 32'h0000_0055);
    send_item(CMD_LOAD, '0, 12'd4, 64'h101, 32'd0, 32'h8000_0000);
    send_item(CMD_LOAD, '0, 12'd5, '1, 32'd0, 32'h0000_0010);
    configure(64'd6, 64'hFFFF_FFFF_FFFF_FFF0, 64'd1);
    // Entries 0x0, 0x101 and all ones share one cache slot.
    lookup(64'd0);
    lookup(64'd0);
    lookup(64'h101);
    lookup(64'd0);
    lookup(64'd5);
    lookup(64'd9);
    lookup('1);
    lookup('1);
    lookup(64'd4);
    send_item(CMD_FLUSH, '1, '1, '1, '1, '1);
    lookup('1);
    // With no code present only cached targets can still be returned.
    configure(64'd6, 64'd0, 64'd256);
    lookup('1);
    lookup(64'd5);
  endtask

  task automatic lookup_table_ends(logic [63:0] first_pc, logic [63:0] last_pc);
    lookup(first_pc);
    lookup(first_pc);
    lookup(first_pc - 64'd1);
    lookup(last_pc);
    lookup(last_pc + 64'd1);
    lookup(last_pc);
    lookup(64'd0);
    lookup('1);
  endtask

  task automatic test_full_table();
    logic [63:0] base;
    logic [63:0] first_pc;
    logic [63:0] last_pc;
    int          pos;
    int          lo;
    int          hi;
    base     = rand64();
    first_pc = {32'd1, $urandom};
    last_pc  = first_pc + 64'(TABLE_DEPTH - 1) * 64'h10;
    // Keys at or beyond either end of a full-depth table are searched only along the
    // leftmost or the rightmost path, so only the entries on those paths are loaded.
    send_item(CMD_LOAD, rand64(), 12'd0, first_pc, 32'd0, $urandom);
    pos = 1;
    while (pos < TABLE_DEPTH) begin
      send_item(CMD_LOAD, rand64(), 12'(pos), first_pc + 64'(pos) * 64'h10, 32'd0, $urandom);
      pos = pos * 2;
    end
    lo = TABLE_DEPTH / 2 + 1;
    hi = TABLE_DEPTH;
    while (lo < hi) begin
      pos = lo + (hi - lo) / 2;
      send_item(CMD_LOAD, rand64(), 12'(pos), first_pc + 64'(pos) * 64'h10, 32'd0, $urandom);
      lo = pos + 1;
    end
    configure('1, base, 64'd256);
    lookup_table_ends(first_pc, last_pc);
    configure(64'(TABLE_DEPTH), ~base, 64'd0);
    send_item(CMD_FLUSH, rand64(), 12'($urandom), rand64(), $urandom, $urandom);
    lookup_table_ends(first_pc, last_pc);
  endtask

  task automatic test_random_traffic();
    int          first;
    int          n;
    logic [63:0] count;
    logic [63:0] base;
    logic [63:0] mirror;
    first = items_sent;
    while (items_sent - first < 580) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 200) : $urandom_range(2, 40);
      load_sorted_table(n);
      case ($urandom_range(0, 9))
        0:       count = $urandom_range(0, n);
        default: count = n;
      endcase
      case ($urandom_range(0, 9))
        0:       base = '0;
        1:       base = '1;
        default: base = rand64();
      endcase
      case ($urandom_range(0, 4))
        0:       mirror = '0;
        1:       mirror = 64'd256;
        2:       mirror = rand64();
        default: mirror = $urandom_range(1, 255);
      endcase
      configure(count, base, mirror);
      repeat ($urandom_range(20, 50)) send_traffic_item(n);
    end
  endtask

  task automatic finish_run();
    int waited;
    in_if.valid <= 1'b0;
    waited = 0;
    while (due_responses.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (due_responses.size() != 0) begin
      report($sformatf("%0d expected results never arrived", due_responses.size()));
    end
    $display("Sent %0d commands over %0d register writes, with searches over %0d entries.",
             items_sent, cfg_writes, TABLE_DEPTH);
    $display("Results: %0d hits, %0d fills (%0d mirror writes), %0d not found, %0d done.",
             n_hit, n_fill, n_mirror, n_miss, n_done);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  endtask

  always @(negedge clk) begin
    tblc_resp_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (due_responses.size() == 0) begin
        report($sformatf("result transfer with status %0d and no command pending",
                         out_if.status));
      end else begin
        want = due_responses.pop_front();
        if (out_if.status !== want.status)
          report($sformatf("status %0d, expected %0d", out_if.status, want.status));
        if (out_if.target !== want.target)
          report($sformatf("target %h, expected %h", out_if.target, want.target));
        if (out_if.mirror_write !== want.mwrite)
          report($sformatf("mirror_write %b, expected %b", out_if.mirror_write, want.mwrite));
        if (out_if.mirror_slot !== want.mslot)
          report($sformatf("mirror_slot %0d, expected %0d", out_if.mirror_slot, want.mslot));
        case (want.status)
          RESP_HIT:  n_hit++;
          RESP_FILL: n_fill++;
          RESP_MISS: n_miss++;
          default:   n_done++;
        endcase
        if (want.mwrite) n_mirror++;
      end
    end
  end

  // The result side stalls in one of four randomly chosen ready modes.
  initial begin
    int mode;
    int left;
    int tick;
    out_if.ready = 1'b0;
    mode = 0;
    left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 150);
      end
      left--;
      tick++;
      case (mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 3) != 0);
        2:       out_if.ready <= ((tick % 7) < 4);
        default: out_if.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  initial begin
    in_if.valid        = 1'b0;
    in_if.cmd          = CMD_NOP;
    in_if.lookup_pc    = '0;
    in_if.entry_index  = '0;
    in_if.entry_pc     = '0;
    in_if.entry_flags  = '0;
    in_if.entry_offset = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    count_reg  = '0;
    base_reg   = '0;
    mirror_reg = '0;
    foreach (slot_valid[i]) begin
      slot_valid[i]  = 1'b0;
      slot_tag[i]    = '1;
      slot_target[i] = '0;
    end
    mismatches = 0;
    items_sent = 0;
    burst_left = 0;
    cfg_writes = 0;
    n_hit      = 0;
    n_fill     = 0;
    n_miss     = 0;
    n_done     = 0;
    n_mirror   = 0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random_traffic();
    finish_run();
  end

endmodule
